### sv/lsx_pkg.sv
package lsx_pkg;

   localparam int ByteWidth  = 8;
   localparam int WordWidth  = 32;
   localparam int MagicWidth = 64;
   localparam int MlenWidth  = 4;
   localparam int KindWidth  = 3;
   localparam int ErrWidth   = 2;
   localparam int IndexWidth = 2;
   localparam int BitCntWidth = 5;
   // result data: field_value then error_code, padded to whole bytes
   localparam int RspDataWidth = 40;

   localparam logic [MlenWidth-1:0] MagicMax = 4'd8;

   // register reset values
   localparam logic [ByteWidth-1:0]  HeaderSkipReset   = 8'd54;
   localparam logic [MlenWidth-1:0]  MagicLengthReset  = 4'd2;
   localparam logic [MagicWidth-1:0] MagicWordReset    = 64'd10787;
   localparam logic [ByteWidth-1:0]  MaxExtLengthReset = 8'd8;

   // register indexes
   localparam logic [IndexWidth-1:0] RegHeaderSkip   = 2'd0;
   localparam logic [IndexWidth-1:0] RegMagicLength  = 2'd1;
   localparam logic [IndexWidth-1:0] RegMagicWord    = 2'd2;
   localparam logic [IndexWidth-1:0] RegMaxExtLength = 2'd3;

   // field kinds
   localparam logic [KindWidth-1:0] KindMagicOk  = 3'd0;
   localparam logic [KindWidth-1:0] KindExtLen   = 3'd1;
   localparam logic [KindWidth-1:0] KindExtChar  = 3'd2;
   localparam logic [KindWidth-1:0] KindDataLen  = 3'd3;
   localparam logic [KindWidth-1:0] KindDataByte = 3'd4;
   localparam logic [KindWidth-1:0] KindError    = 3'd5;

   // error codes
   localparam logic [ErrWidth-1:0] ErrNone     = 2'd0;
   localparam logic [ErrWidth-1:0] ErrMagic    = 2'd1;
   localparam logic [ErrWidth-1:0] ErrExtLong  = 2'd2;

   typedef struct packed {
      logic [ByteWidth-1:0]  header_skip;
      logic [MlenWidth-1:0]  magic_length;
      logic [MagicWidth-1:0] magic_word;
      logic [ByteWidth-1:0]  max_ext_length;
   } cfg_type;

   typedef struct packed {
      logic                  valid;
      logic [KindWidth-1:0]  kind;
      logic [WordWidth-1:0]  value;
      logic [ErrWidth-1:0]   err;
      logic                  last;
   } res_type;

endpackage

### sv/lsx_csr.sv
module lsx_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [lsx_pkg::IndexWidth-1:0]     csr_index,
   input  logic [lsx_pkg::MagicWidth-1:0]     csr_data,
   output lsx_pkg::cfg_type                   cfg
);

   lsx_pkg::cfg_type cfg_ff;
   lsx_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            lsx_pkg::RegHeaderSkip:   cfg_in.header_skip    = csr_data[lsx_pkg::ByteWidth-1:0];
            lsx_pkg::RegMagicLength:  cfg_in.magic_length   = csr_data[lsx_pkg::MlenWidth-1:0];
            lsx_pkg::RegMagicWord:    cfg_in.magic_word     = csr_data;
            lsx_pkg::RegMaxExtLength: cfg_in.max_ext_length = csr_data[lsx_pkg::ByteWidth-1:0];
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.header_skip    <= lsx_pkg::HeaderSkipReset;
         cfg_ff.magic_length   <= lsx_pkg::MagicLengthReset;
         cfg_ff.magic_word     <= lsx_pkg::MagicWordReset;
         cfg_ff.max_ext_length <= lsx_pkg::MaxExtLengthReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### sv/lsx_parser.sv
module lsx_parser (
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  logic             cover_bit,
   input  logic             frame_start,
   input  lsx_pkg::cfg_type cfg,
   output lsx_pkg::res_type res
);

   localparam logic [2:0] PhHeader  = 3'd0;
   localparam logic [2:0] PhMagic   = 3'd1;
   localparam logic [2:0] PhExtLen  = 3'd2;
   localparam logic [2:0] PhExtChr  = 3'd3;
   localparam logic [2:0] PhDataLen = 3'd4;
   localparam logic [2:0] PhData    = 3'd5;
   localparam logic [2:0] PhIdle    = 3'd6;

   localparam logic [lsx_pkg::BitCntWidth-1:0] CharTop = 5'd7;
   localparam logic [lsx_pkg::BitCntWidth-1:0] WordTop = 5'd31;

   logic [2:0]                          phase_ff, phase_in;
   logic [lsx_pkg::ByteWidth-1:0]       hdr_cnt_ff, hdr_cnt_in;
   logic [lsx_pkg::BitCntWidth-1:0]     bit_cnt_ff, bit_cnt_in;
   logic [lsx_pkg::WordWidth-1:0]       shift_ff, shift_in;
   logic [lsx_pkg::MlenWidth-1:0]       magic_idx_ff, magic_idx_in;
   logic [lsx_pkg::WordWidth-1:0]       remain_ff, remain_in;

   always_comb begin
      logic [2:0]                      ph;
      logic [lsx_pkg::ByteWidth-1:0]   hc;
      logic [lsx_pkg::BitCntWidth-1:0] bc;
      logic [lsx_pkg::WordWidth-1:0]   sh;
      logic [lsx_pkg::MlenWidth-1:0]   mi;
      logic [lsx_pkg::MlenWidth-1:0]   mi_next;
      logic [lsx_pkg::WordWidth-1:0]   rem;
      logic [lsx_pkg::WordWidth-1:0]   rem_dec;
      logic [lsx_pkg::MlenWidth-1:0]   mlen;
      logic [lsx_pkg::BitCntWidth-1:0] top;
      logic                            done;
      logic [lsx_pkg::WordWidth-1:0]   sh_new;
      logic [lsx_pkg::ByteWidth-1:0]   chr;
      logic [lsx_pkg::ByteWidth-1:0]   expect_chr;
      logic                            gathering;

      if (frame_start) begin
         ph  = PhHeader;
         hc  = '0;
         bc  = '0;
         sh  = '0;
         mi  = '0;
         rem = '0;
      end else begin
         ph  = phase_ff;
         hc  = hdr_cnt_ff;
         bc  = bit_cnt_ff;
         sh  = shift_ff;
         mi  = magic_idx_ff;
         rem = remain_ff;
      end

      mlen = (cfg.magic_length > lsx_pkg::MagicMax) ? lsx_pkg::MagicMax : cfg.magic_length;

      res       = '0;
      gathering = 1'b0;

      if (ph == PhHeader) begin
         if (hc < cfg.header_skip) begin
            hc = hc + 8'd1;
         end else begin
            ph = PhMagic;
         end
      end
      if (ph == PhMagic && mi >= mlen) begin
         ph = PhExtLen;
      end

      // a char or a word completes when the bit count hits its last index
      top = (ph == PhExtLen || ph == PhDataLen) ? WordTop : CharTop;
      gathering = (ph == PhMagic) || (ph == PhExtLen) || (ph == PhExtChr) ||
                  (ph == PhDataLen) || (ph == PhData);
      done   = (bc == top);
      sh_new = {sh[lsx_pkg::WordWidth-2:0], cover_bit};
      chr    = sh_new[lsx_pkg::ByteWidth-1:0];
      expect_chr = cfg.magic_word[{mi[2:0], 3'b000} +: lsx_pkg::ByteWidth];
      mi_next = mi + 4'd1;
      rem_dec = (rem != '0) ? rem - 32'd1 : '0;

      if (gathering) begin
         sh = sh_new;
         bc = done ? '0 : bc + 5'd1;
      end

      if (gathering && done) begin
         sh = '0;
         unique case (ph)
            PhMagic: begin
               if (chr != expect_chr) begin
                  ph  = PhIdle;
                  res = '{1'b1, lsx_pkg::KindError, {24'd0, chr}, lsx_pkg::ErrMagic, 1'b1};
               end else begin
                  mi = mi_next;
                  if (mi_next >= mlen) begin
                     ph  = PhExtLen;
                     res = '{1'b1, lsx_pkg::KindMagicOk, 32'd0, lsx_pkg::ErrNone, 1'b0};
                  end
               end
            end
            PhExtLen: begin
               if (sh_new > {24'd0, cfg.max_ext_length}) begin
                  ph  = PhIdle;
                  res = '{1'b1, lsx_pkg::KindError, sh_new, lsx_pkg::ErrExtLong, 1'b1};
               end else begin
                  rem = sh_new;
                  ph  = (sh_new != '0) ? PhExtChr : PhDataLen;
                  res = '{1'b1, lsx_pkg::KindExtLen, sh_new, lsx_pkg::ErrNone, 1'b0};
               end
            end
            PhExtChr: begin
               rem = rem_dec;
               if (rem_dec == '0) ph = PhDataLen;
               res = '{1'b1, lsx_pkg::KindExtChar, {24'd0, chr}, lsx_pkg::ErrNone, 1'b0};
            end
            PhDataLen: begin
               rem = sh_new;
               ph  = (sh_new != '0) ? PhData : PhIdle;
               res = '{1'b1, lsx_pkg::KindDataLen, sh_new, lsx_pkg::ErrNone, sh_new == '0};
            end
            PhData: begin
               rem = rem_dec;
               if (rem_dec == '0) ph = PhIdle;
               res = '{1'b1, lsx_pkg::KindDataByte, {24'd0, chr}, lsx_pkg::ErrNone,
                       rem_dec == '0};
            end
            default: res = '0;
         endcase
      end

      phase_in     = ph;
      hdr_cnt_in   = hc;
      bit_cnt_in   = bc;
      shift_in     = sh;
      magic_idx_in = mi;
      remain_in    = rem;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PhHeader;
         hdr_cnt_ff   <= '0;
         bit_cnt_ff   <= '0;
         shift_ff     <= '0;
         magic_idx_ff <= '0;
         remain_ff    <= '0;
      end else if (step) begin
         phase_ff     <= phase_in;
         hdr_cnt_ff   <= hdr_cnt_in;
         bit_cnt_ff   <= bit_cnt_in;
         shift_ff     <= shift_in;
         magic_idx_ff <= magic_idx_in;
         remain_ff    <= remain_in;
      end
   end

endmodule

### sv/lsb_stego_stream_extractor.sv
// Result path: an accepted cover byte loads the input register; the parse step then loads its
// result word, if any, into the result register, which drives rsp_*; a stalled rsp_* holds the step.
// Throughput: one cover byte per cycle while rsp_* is not stalled; the parse step is a single
// pass of shift, compare and decrement logic between the two registers.
// Reset (synchronous, active high) empties both registers, restarts the parse
// in the header phase and loads the register defaults.
module lsb_stego_stream_extractor (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [lsx_pkg::ByteWidth-1:0]        req_tdata,  // [7:0] cover_byte
   input  logic                                 req_tuser,  // [0] frame_start
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [lsx_pkg::RspDataWidth-1:0]     rsp_tdata,  // [31:0] field_value, [33:32] error_code
   output logic [lsx_pkg::KindWidth-1:0]        rsp_tuser,  // [2:0] field_kind
   output logic                                 rsp_tlast,  // last
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [lsx_pkg::IndexWidth-1:0]       csr_index,
   input  logic [lsx_pkg::MagicWidth-1:0]       csr_data
);

   lsx_pkg::cfg_type cfg;
   lsx_pkg::res_type res;

   logic in_valid_ff, in_valid_in;
   logic in_bit_ff;
   logic in_fs_ff;
   logic rsp_valid_ff, rsp_valid_in;
   logic [lsx_pkg::KindWidth-1:0] rsp_kind_ff;
   logic [lsx_pkg::WordWidth-1:0] rsp_value_ff;
   logic [lsx_pkg::ErrWidth-1:0]  rsp_err_ff;
   logic rsp_last_ff;
   logic out_ready;
   logic step;

   lsx_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   lsx_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .cover_bit   (in_bit_ff),
      .frame_start (in_fs_ff),
      .cfg         (cfg),
      .res         (res)
   );

   assign out_ready   = !rsp_valid_ff || rsp_tready;
   assign step        = in_valid_ff && out_ready;
   assign req_tready  = !in_valid_ff || out_ready;
   assign in_valid_in = req_tready ? req_tvalid : in_valid_ff;
   assign rsp_valid_in = out_ready ? (step && res.valid) : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // only bit 0 of a cover byte carries hidden data
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_bit_ff <= req_tdata[0];
         in_fs_ff  <= req_tuser;
      end
      if (step && out_ready) begin
         rsp_kind_ff  <= res.kind;
         rsp_value_ff <= res.value;
         rsp_err_ff   <= res.err;
         rsp_last_ff  <= res.last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(lsx_pkg::RspDataWidth - lsx_pkg::WordWidth - lsx_pkg::ErrWidth){1'b0}},
                        rsp_err_ff, rsp_value_ff};
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

### sv/lsx_checker.sv
module lsx_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [lsx_pkg::RspDataWidth-1:0]   rsp_tdata,
   input logic [lsx_pkg::KindWidth-1:0]      rsp_tuser,
   input logic                               rsp_tlast
);

   // a stalled word keeps its contents
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
      $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result word changed while stalled");

   // errors always close the frame and carry a nonzero code
   a_err_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == lsx_pkg::KindError |->
      rsp_tlast && (rsp_tdata[33:32] == lsx_pkg::ErrMagic ||
                    rsp_tdata[33:32] == lsx_pkg::ErrExtLong))
      else $error("error word malformed");

   // non-error words carry no error code
   a_ok_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != lsx_pkg::KindError |-> rsp_tdata[33:32] == lsx_pkg::ErrNone)
      else $error("error code on a normal word");

   // characters fit in one byte
   a_char_width: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == lsx_pkg::KindExtChar || rsp_tuser == lsx_pkg::KindDataByte)
      |-> rsp_tdata[31:8] == 24'd0)
      else $error("character wider than a byte");

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind lsb_stego_stream_extractor lsx_checker u_lsx_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

### bench/tb_lsb_stego_stream_extractor.sv
`timescale 1ns / 1ps

module tb_lsb_stego_stream_extractor;

   typedef enum logic [2:0] {
      PhHeader, PhMagic, PhExtLen, PhExtChr, PhDataLen, PhData, PhIdle
   } phase_type;

   typedef enum logic [1:0] {RowHeader, RowBits, RowCsr} row_op_type;

   // n: frame start flag for RowHeader, bit count for RowBits, index for RowCsr
   typedef struct packed {
      row_op_type        op;
      logic [7:0]        n;
      logic [63:0]       arg;
      lsx_pkg::res_type  want;
   } plan_row_type;

   localparam lsx_pkg::res_type NoField = '0;

   logic                                 clock = 1'b0;
   logic                                 reset = 1'b1;
   logic                                 req_tvalid = 1'b0;
   logic                                 req_tready;
   logic [lsx_pkg::ByteWidth-1:0]        req_tdata = '0;
   logic                                 req_tuser = 1'b0;
   logic                                 rsp_tvalid;
   logic                                 rsp_tready = 1'b0;
   logic [lsx_pkg::RspDataWidth-1:0]     rsp_tdata;
   logic [lsx_pkg::KindWidth-1:0]        rsp_tuser;
   logic                                 rsp_tlast;
   logic                                 csr_valid = 1'b0;
   logic                                 csr_ready;
   logic [lsx_pkg::IndexWidth-1:0]       csr_index = '0;
   logic [lsx_pkg::MagicWidth-1:0]       csr_data = '0;

   // decoder copy of the block
   lsx_pkg::cfg_type         regs;
   phase_type                phase;
   logic [7:0]               hdr_count;
   logic [4:0]               bit_count;
   logic [31:0]              shreg;
   logic [3:0]               magic_pos;
   logic [31:0]              remaining;

   lsx_pkg::res_type         pending_fields[$];
   plan_row_type             script[$];
   bit                       pend_fs = 1'b0;
   bit                       calm = 1'b0;
   int                       bit_budget = -1;
   int                       hold_left = 0;
   int                       errors = 0;
   int                       bytes_taken = 0;
   int                       fields_seen = 0;
   int                       frames_sent = 0;
   int                       csr_writes = 0;

   lsb_stego_stream_extractor uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic lsx_pkg::res_type make_field(logic [lsx_pkg::KindWidth-1:0] kind,
                                                   logic [31:0] value,
                                                   logic [lsx_pkg::ErrWidth-1:0] err,
                                                   logic last);
      lsx_pkg::res_type r;
      r.valid = 1'b1;
      r.kind  = kind;
      r.value = value;
      r.err   = err;
      r.last  = last;
      return r;
   endfunction

   function automatic void rewind_parse();
      phase     = PhHeader;
      hdr_count = '0;
      bit_count = '0;
      shreg     = '0;
      magic_pos = '0;
      remaining = '0;
   endfunction

   // shift one hidden bit in, msb first; true once bit index top has arrived
   function automatic logic take_bit(logic b, logic [4:0] top);
      logic done;
      done = (bit_count == top);
      shreg = {shreg[30:0], b};
      bit_count = done ? 5'd0 : bit_count + 5'd1;
      return done;
   endfunction

   function automatic lsx_pkg::res_type decode_cover_byte(logic [7:0] cb, logic fs);
      lsx_pkg::res_type r;
      logic [3:0]       mlen;
      logic [31:0]      v;
      r = NoField;
      mlen = (regs.magic_length > lsx_pkg::MagicMax) ? lsx_pkg::MagicMax : regs.magic_length;
      if (fs)
         rewind_parse();
      if (phase == PhHeader) begin
         if (hdr_count < regs.header_skip) begin
            hdr_count = hdr_count + 8'd1;
            return r;
         end
         phase = PhMagic;
      end
      // magic length may have been cut below what is already matched
      if (phase == PhMagic && magic_pos >= mlen)
         phase = PhExtLen;
      case (phase)
         PhMagic: if (take_bit(cb[0], 5'd7)) begin
            v = {24'd0, shreg[7:0]};
            shreg = '0;
            if (v[7:0] != regs.magic_word[magic_pos[2:0]*8 +: 8]) begin
               phase = PhIdle;
               r = make_field(lsx_pkg::KindError, v, lsx_pkg::ErrMagic, 1'b1);
            end else begin
               magic_pos = magic_pos + 4'd1;
               if (magic_pos >= mlen) begin
                  phase = PhExtLen;
                  r = make_field(lsx_pkg::KindMagicOk, 32'd0, lsx_pkg::ErrNone, 1'b0);
               end
            end
         end
         PhExtLen: if (take_bit(cb[0], 5'd31)) begin
            v = shreg;
            shreg = '0;
            if (v > {24'd0, regs.max_ext_length}) begin
               phase = PhIdle;
               r = make_field(lsx_pkg::KindError, v, lsx_pkg::ErrExtLong, 1'b1);
            end else begin
               remaining = v;
               phase = (v != 0) ? PhExtChr : PhDataLen;
               r = make_field(lsx_pkg::KindExtLen, v, lsx_pkg::ErrNone, 1'b0);
            end
         end
         PhExtChr: if (take_bit(cb[0], 5'd7)) begin
            v = {24'd0, shreg[7:0]};
            shreg = '0;
            if (remaining != 0)
               remaining = remaining - 32'd1;
            if (remaining == 0)
               phase = PhDataLen;
            r = make_field(lsx_pkg::KindExtChar, v, lsx_pkg::ErrNone, 1'b0);
         end
         PhDataLen: if (take_bit(cb[0], 5'd31)) begin
            v = shreg;
            shreg = '0;
            remaining = v;
            phase = (v != 0) ? PhData : PhIdle;
            r = make_field(lsx_pkg::KindDataLen, v, lsx_pkg::ErrNone, v == 0);
         end
         PhData: if (take_bit(cb[0], 5'd7)) begin
            v = {24'd0, shreg[7:0]};
            shreg = '0;
            if (remaining != 0)
               remaining = remaining - 32'd1;
            if (remaining == 0)
               phase = PhIdle;
            r = make_field(lsx_pkg::KindDataByte, v, lsx_pkg::ErrNone, remaining == 0);
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic int pick_gap();
      int r;
      if (calm)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(5, 40);
   endfunction

   task automatic report_mismatch(string what, logic [63:0] exp_v, logic [63:0] got_v);
      errors++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, exp_v, got_v);
   endtask

   // entered and left at a falling edge
   task automatic drive_byte(logic [7:0] b, lsx_pkg::res_type want);
      int               g;
      lsx_pkg::res_type got;
      g = pick_gap();
      if (g > 0) begin
         req_tvalid <= 1'b0;
         repeat (g) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tuser  <= pend_fs;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      bytes_taken++;
      got = decode_cover_byte(b, pend_fs);
      pend_fs = 1'b0;
      if (want.valid)
         pending_fields.push_back(want);
      else if (got.valid)
         pending_fields.push_back(got);
      @(negedge clock);
   endtask

   // hidden bits ride in bit 0, the rest of the byte is noise
   task automatic send_bits(logic [31:0] val, int n, lsx_pkg::res_type want);
      logic [7:0] rb;
      for (int i = n - 1; i >= 0; i--) begin
         if (bit_budget == 0)
            return;
         if (bit_budget > 0)
            bit_budget--;
         rb = 8'($urandom);
         rb[0] = val[i];
         drive_byte(rb, (i == 0) ? want : NoField);
      end
   endtask

   task automatic send_header(logic fs);
      pend_fs = fs;
      frames_sent++;
      repeat (regs.header_skip)
         drive_byte(8'($urandom), NoField);
   endtask

   task automatic write_reg(logic [lsx_pkg::IndexWidth-1:0] idx, logic [63:0] val);
      req_tvalid <= 1'b0;
      while (pending_fields.size() != 0)
         @(negedge clock);
      // a byte with no result may still be in flight
      repeat (4) @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      case (idx)
         lsx_pkg::RegHeaderSkip:   regs.header_skip    = val[7:0];
         lsx_pkg::RegMagicLength:  regs.magic_length   = val[3:0];
         lsx_pkg::RegMagicWord:    regs.magic_word     = val;
         lsx_pkg::RegMaxExtLength: regs.max_ext_length = val[7:0];
         default: ;
      endcase
      csr_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic add_row(row_op_type op, logic [7:0] n, logic [63:0] arg,
                          lsx_pkg::res_type want);
      plan_row_type row;
      row.op   = op;
      row.n    = n;
      row.arg  = arg;
      row.want = want;
      script.push_back(row);
   endtask

   task automatic shuffle_regs();
      int r;
      r = $urandom_range(0, 9);
      write_reg(lsx_pkg::RegHeaderSkip, (r == 0) ? 64'd255 : (r == 1) ? 64'd54 :
                64'($urandom_range(0, 6)));
      r = $urandom_range(0, 3);
      write_reg(lsx_pkg::RegMagicLength,
                64'((r == 0) ? $urandom_range(0, 15) : $urandom_range(0, 3)));
      write_reg(lsx_pkg::RegMagicWord, {$urandom, $urandom});
      r = $urandom_range(0, 9);
      write_reg(lsx_pkg::RegMaxExtLength, (r == 0) ? 64'd255 : 64'($urandom_range(0, 6)));
   endtask

   // mostly well formed frames; some spoilt magic, oversize extensions and cut frames
   task automatic random_frame();
      logic [3:0]  mlen;
      logic [31:0] ext_len;
      logic [31:0] data_len;
      logic [7:0]  ch;
      int          spoil;
      int          lim;
      int          n;
      bit          broken;
      if ($urandom_range(0, 2) == 0)
         shuffle_regs();
      calm = ($urandom_range(0, 4) == 0);
      bit_budget = ($urandom_range(0, 9) == 0) ? int'($urandom_range(1, 60)) : -1;
      send_header($urandom_range(0, 9) != 0);
      mlen = (regs.magic_length > lsx_pkg::MagicMax) ? lsx_pkg::MagicMax : regs.magic_length;
      spoil = ($urandom_range(0, 11) == 0) ? int'($urandom_range(0, 7)) : 8;
      broken = (spoil < int'(mlen));
      for (int i = 0; i < int'(mlen) && i <= spoil; i++) begin
         ch = regs.magic_word[i*8 +: 8];
         if (i == spoil)
            ch = ch ^ 8'($urandom_range(1, 255));
         send_bits({24'd0, ch}, 8, NoField);
      end
      if (!broken) begin
         if ($urandom_range(0, 9) == 0) begin
            ext_len = ($urandom_range(0, 1) == 0) ? {24'd0, regs.max_ext_length} + 32'd1
                                                  : $urandom;
            broken = (ext_len > {24'd0, regs.max_ext_length});
         end else begin
            lim = (regs.max_ext_length > 8'd6) ? 6 : int'(regs.max_ext_length);
            if ($urandom_range(0, 3) == 0 && regs.max_ext_length <= 8'd16)
               ext_len = {24'd0, regs.max_ext_length};
            else
               ext_len = $urandom_range(0, lim);
         end
         send_bits(ext_len, 32, NoField);
      end
      if (!broken) begin
         for (int j = 0; j < int'(ext_len); j++)
            send_bits(32'($urandom_range(0, 255)), 8, NoField);
         data_len = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 6);
         send_bits(data_len, 32, NoField);
         // huge lengths are cut short by the next frame start
         n = (data_len > 32'd6) ? int'($urandom_range(0, 4)) : int'(data_len);
         repeat (n)
            send_bits(32'($urandom_range(0, 255)), 8, NoField);
      end
      bit_budget = -1;
      repeat ($urandom_range(0, 3))
         drive_byte(8'($urandom), NoField);
   endtask

   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if (!calm && $urandom_range(0, 3) == 0)
            hold_left = pick_gap();
      end
   end

   always @(posedge clock) begin : rsp_check
      lsx_pkg::res_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         fields_seen++;
         if (pending_fields.size() == 0) begin
            report_mismatch("unexpected word", 64'd0, {21'd0, rsp_tuser, rsp_tdata});
         end else begin
            want = pending_fields.pop_front();
            if (rsp_tuser !== want.kind)
               report_mismatch("field_kind", 64'(want.kind), 64'(rsp_tuser));
            if (rsp_tdata[lsx_pkg::WordWidth-1:0] !== want.value)
               report_mismatch("field_value", 64'(want.value),
                               64'(rsp_tdata[lsx_pkg::WordWidth-1:0]));
            if (rsp_tdata[lsx_pkg::WordWidth +: lsx_pkg::ErrWidth] !== want.err)
               report_mismatch("error_code", 64'(want.err),
                               64'(rsp_tdata[lsx_pkg::WordWidth +: lsx_pkg::ErrWidth]));
            if (rsp_tlast !== want.last)
               report_mismatch("last", 64'(want.last), 64'(rsp_tlast));
            if (rsp_tdata[lsx_pkg::RspDataWidth-1:lsx_pkg::WordWidth+lsx_pkg::ErrWidth] !== '0)
               report_mismatch("tdata padding", 64'd0,
                  64'(rsp_tdata[lsx_pkg::RspDataWidth-1:lsx_pkg::WordWidth+lsx_pkg::ErrWidth]));
         end
      end
   end

   initial begin
      regs.header_skip    = lsx_pkg::HeaderSkipReset;
      regs.magic_length   = lsx_pkg::MagicLengthReset;
      regs.magic_word     = lsx_pkg::MagicWordReset;
      regs.max_ext_length = lsx_pkg::MaxExtLengthReset;
      rewind_parse();

      // defaults: 54 header bytes, magic "#*", extension limit 8
      add_row(RowHeader, 8'd0, 64'd0, NoField);      // no frame start after reset
      add_row(RowBits, 8'd8, 64'h23, NoField);
      add_row(RowBits, 8'd8, 64'h2A,
              make_field(lsx_pkg::KindMagicOk, 32'd0, lsx_pkg::ErrNone, 1'b0));
      add_row(RowBits, 8'd32, 64'd3,
              make_field(lsx_pkg::KindExtLen, 32'd3, lsx_pkg::ErrNone, 1'b0));
      add_row(RowBits, 8'd8, 64'h00,
              make_field(lsx_pkg::KindExtChar, 32'h00, lsx_pkg::ErrNone, 1'b0));
      add_row(RowBits, 8'd8, 64'hFF,
              make_field(lsx_pkg::KindExtChar, 32'hFF, lsx_pkg::ErrNone, 1'b0));
      add_row(RowBits, 8'd8, 64'h5A, NoField);
      add_row(RowBits, 8'd32, 64'd1,
              make_field(lsx_pkg::KindDataLen, 32'd1, lsx_pkg::ErrNone, 1'b0));
      add_row(RowBits, 8'd8, 64'h01,
              make_field(lsx_pkg::KindDataByte, 32'h01, lsx_pkg::ErrNone, 1'b1));
      add_row(RowBits, 8'd8, 64'hC3, NoField);       // ignored once the payload is done
      // no header, no magic: frame start lands on a hidden bit
      add_row(RowCsr, 8'(lsx_pkg::RegHeaderSkip), 64'd0, NoField);
      add_row(RowCsr, 8'(lsx_pkg::RegMagicLength), 64'd0, NoField);
      add_row(RowHeader, 8'd1, 64'd0, NoField);
      add_row(RowBits, 8'd32, 64'd0,
              make_field(lsx_pkg::KindExtLen, 32'd0, lsx_pkg::ErrNone, 1'b0));
      add_row(RowBits, 8'd32, 64'd0,
              make_field(lsx_pkg::KindDataLen, 32'd0, lsx_pkg::ErrNone, 1'b1));
      add_row(RowCsr, 8'(lsx_pkg::RegMaxExtLength), 64'd255, NoField);
      add_row(RowHeader, 8'd1, 64'd0, NoField);
      add_row(RowBits, 8'd32, 64'hFFFF_FFFF,
              make_field(lsx_pkg::KindError, 32'hFFFF_FFFF, lsx_pkg::ErrExtLong, 1'b1));
      // eight magic characters, partial field dropped by a new frame start
      add_row(RowCsr, 8'(lsx_pkg::RegMagicWord), 64'hFFFF_FFFF_FFFF_FFFF, NoField);
      add_row(RowCsr, 8'(lsx_pkg::RegMagicLength), 64'd15, NoField);
      add_row(RowHeader, 8'd1, 64'd0, NoField);
      add_row(RowBits, 8'd5, 64'h1F, NoField);
      add_row(RowHeader, 8'd1, 64'd0, NoField);
      add_row(RowBits, 8'd8, 64'hFF, NoField);
      add_row(RowBits, 8'd8, 64'hFF, NoField);
      // magic length cut to no more than the count matched so far: leaves magic silently
      add_row(RowCsr, 8'(lsx_pkg::RegMagicLength), 64'd2, NoField);
      add_row(RowBits, 8'd32, 64'd1,
              make_field(lsx_pkg::KindExtLen, 32'd1, lsx_pkg::ErrNone, 1'b0));
      add_row(RowBits, 8'd8, 64'h7E, NoField);
      add_row(RowBits, 8'd32, 64'h8000_0001, NoField);
      add_row(RowBits, 8'd8, 64'hA5, NoField);
      add_row(RowCsr, 8'(lsx_pkg::RegMaxExtLength), 64'd0, NoField);
      add_row(RowCsr, 8'(lsx_pkg::RegMagicLength), 64'd1, NoField);
      add_row(RowCsr, 8'(lsx_pkg::RegMagicWord), 64'd0, NoField);
      add_row(RowHeader, 8'd1, 64'd0, NoField);
      add_row(RowBits, 8'd8, 64'h00,
              make_field(lsx_pkg::KindMagicOk, 32'd0, lsx_pkg::ErrNone, 1'b0));
      add_row(RowBits, 8'd32, 64'd1,
              make_field(lsx_pkg::KindError, 32'd1, lsx_pkg::ErrExtLong, 1'b1));
      add_row(RowHeader, 8'd1, 64'd0, NoField);
      add_row(RowBits, 8'd8, 64'h80,
              make_field(lsx_pkg::KindError, 32'h80, lsx_pkg::ErrMagic, 1'b1));

      repeat (5) @(negedge clock);
      reset <= 1'b0;

      foreach (script[k]) begin
         case (script[k].op)
            RowHeader: send_header(script[k].n[0]);
            RowBits:   send_bits(script[k].arg[31:0], int'(script[k].n), script[k].want);
            RowCsr:    write_reg(script[k].n[lsx_pkg::IndexWidth-1:0], script[k].arg);
            default: ;
         endcase
      end

      while (bytes_taken < 1750)
         random_frame();

      req_tvalid <= 1'b0;
      while (pending_fields.size() != 0)
         @(negedge clock);
      repeat (8) @(negedge clock);

      $display("Run: %0d cover bytes over %0d frames, %0d decoded fields checked",
               bytes_taken, frames_sent, fields_seen);
      $display("Run: %0d register writes, header skip 0..255, magic length 0..15",
               csr_writes);
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("Timeout with %0d fields outstanding", pending_fields.size());
      $display("DONE: errors detected");
      $finish;
   end

endmodule

### sim.f
sv/lsx_pkg.sv
sv/lsx_csr.sv
sv/lsx_parser.sv
sv/lsb_stego_stream_extractor.sv
sv/lsx_checker.sv
bench/tb_lsb_stego_stream_extractor.sv
